@@ hdl/dfbe_pkg.sv @@
// Shared types, codes and calendar helpers for the date field button editor.
package dfbe_pkg;

   // Command codes carried on the request tuser
   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_ENTER   = 3'd1,
      CMD_BACK    = 3'd2,
      CMD_UP      = 3'd3,
      CMD_DOWN    = 3'd4,
      CMD_REFRESH = 3'd5
   } cmd_type;

   // Field under edit; zero means not editing
   typedef enum logic [2:0] {
      FIELD_NONE    = 3'd0,
      FIELD_WEEKDAY = 3'd1,
      FIELD_DAY     = 3'd2,
      FIELD_MONTH   = 3'd3,
      FIELD_YEAR    = 3'd4
   } field_type;

   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [2:0]  weekday;
   } date_type;

   typedef struct packed {
      field_type field;
      date_type  date;
   } state_type;

   localparam logic [2:0]  WEEKDAY_MAX   = 3'd6;
   localparam logic [3:0]  MONTH_FIRST   = 4'd1;
   localparam logic [3:0]  MONTH_LAST    = 4'd12;
   localparam logic [3:0]  MONTH_FEB     = 4'd2;
   localparam logic [3:0]  MONTH_APR     = 4'd4;
   localparam logic [3:0]  MONTH_JUN     = 4'd6;
   localparam logic [3:0]  MONTH_SEP     = 4'd9;
   localparam logic [3:0]  MONTH_NOV     = 4'd11;
   localparam logic [4:0]  DAY_FIRST     = 5'd1;
   localparam logic [4:0]  DAYS_LONG     = 5'd31;
   localparam logic [4:0]  DAYS_SHORT    = 5'd30;
   localparam logic [4:0]  DAYS_FEB_LEAP = 5'd29;
   localparam logic [4:0]  DAYS_FEB      = 5'd28;

   localparam logic [2:0]  RESET_WEEKDAY = 3'd0;
   localparam logic [4:0]  RESET_DAY     = 5'd1;
   localparam logic [3:0]  RESET_MONTH   = 4'd1;
   localparam logic [15:0] RESET_YEAR    = 16'd2016;

   // Month length; February is leap when the year is a multiple of four,
   // codes outside 1..12 count as long months
   function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                input logic [15:0] year);
      logic [4:0] len;
      case (month) inside
         MONTH_FEB: len = (year[1:0] == 2'd0) ? DAYS_FEB_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
         default: len = DAYS_LONG;
      endcase
      return len;
   endfunction

endpackage

@@ hdl/date_field_button_editor.sv @@
// Top level: input stage, date state and result register of the button editor.
// An accepted request transaction is held in the input stage, then loads the result register.
// Throughput: one transaction per cycle unless the result side stalls; the date state
// updates in the same cycle the result register loads; the next request sees it at once.
// Reset: synchronous, active high; date returns to weekday 0, day 1, month 1,
// year 2016, not editing, and both stages empty.
module date_field_button_editor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // clock_weekday[2:0], clock_day[7:3],
                                   // clock_month[11:8], clock_year[27:12], zero[31:28]
   input  logic [2:0]  req_tuser,  // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // weekday[2:0], day[7:3], month[11:8], year[27:12],
                                   // selected_field[30:28], commit[31]
);
   import dfbe_pkg::*;

   logic        s1_valid_ff;
   cmd_type     s1_cmd_ff;
   date_type    s1_clock_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   state_type   state_ff;
   state_type   state_in;
   logic        commit_in;
   logic        advance;
   date_type    req_clock;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_clock.weekday = req_tdata[2:0];
   assign req_clock.day     = req_tdata[7:3];
   assign req_clock.month   = req_tdata[11:8];
   assign req_clock.year    = req_tdata[27:12];

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tready) begin
         s1_cmd_ff   <= cmd_type'(req_tuser);
         s1_clock_ff <= req_clock;
      end
   end

   dfbe_step u_step (
      .cur_state  (state_ff),
      .cmd        (s1_cmd_ff),
      .clock_date (s1_clock_ff),
      .next_state (state_in),
      .commit     (commit_in)
   );

   // Advance the date state with each transaction passed on
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.field        <= FIELD_NONE;
         state_ff.date.weekday <= RESET_WEEKDAY;
         state_ff.date.day     <= RESET_DAY;
         state_ff.date.month   <= RESET_MONTH;
         state_ff.date.year    <= RESET_YEAR;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Hold the result until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_data_ff <= {commit_in, state_in.field, state_in.date.year,
                         state_in.date.month, state_in.date.day,
                         state_in.date.weekday};
      end
   end

   // A commit strobe always comes with edit mode left
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[31] |-> rsp_data_ff[30:28] == FIELD_NONE)
      else $error("commit result while still editing");

   // Selection never leaves the field range
   assert property (@(posedge clock) disable iff (reset)
      state_ff.field <= FIELD_YEAR)
      else $error("selected field out of range");

   // State changes only when a transaction passes to the result side
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("date state changed without a transaction");

   // Both stages are empty after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("stage valid after reset");

endmodule

@@ hdl/dfbe_step.sv @@
// Next-state logic for one button or refresh transaction.
module dfbe_step (
   input  dfbe_pkg::state_type cur_state,
   input  dfbe_pkg::cmd_type   cmd,
   input  dfbe_pkg::date_type  clock_date,
   output dfbe_pkg::state_type next_state,
   output logic                commit
);
   import dfbe_pkg::*;

   logic       editing;
   logic       up;
   logic [4:0] cur_len;
   logic [4:0] new_len;
   logic [3:0] new_month;
   date_type   d;

   assign editing = (cur_state.field != FIELD_NONE);
   assign up      = (cmd == CMD_UP);
   assign d       = cur_state.date;
   assign cur_len = days_in_month(d.month, d.year);

   // Step the month with wrap and find its length for the day clamp
   always_comb begin
      if (up) begin
         new_month = (d.month >= MONTH_LAST) ? MONTH_FIRST : d.month + 4'd1;
      end else begin
         new_month = (d.month <= MONTH_FIRST) ? MONTH_LAST : d.month - 4'd1;
      end
   end
   assign new_len = days_in_month(new_month, d.year);

   // Decode the command and update selection or date
   always_comb begin
      next_state = cur_state;
      commit     = 1'b0;
      unique case (cmd)
         CMD_ENTER: begin
            unique case (cur_state.field)
               FIELD_NONE:  next_state.field = FIELD_WEEKDAY;
               FIELD_WEEKDAY: next_state.field = FIELD_DAY;
               FIELD_DAY:   next_state.field = FIELD_MONTH;
               FIELD_MONTH: next_state.field = FIELD_YEAR;
               default:     next_state.field = FIELD_WEEKDAY;
            endcase
         end
         CMD_BACK: begin
            if (editing) begin
               next_state.field = FIELD_NONE;
               commit           = 1'b1;
            end
         end
         CMD_UP, CMD_DOWN: begin
            if (editing) begin
               unique case (cur_state.field)
                  FIELD_WEEKDAY: begin
                     if (up) begin
                        next_state.date.weekday =
                           (d.weekday >= WEEKDAY_MAX) ? 3'd0 : d.weekday + 3'd1;
                     end else begin
                        next_state.date.weekday =
                           (d.weekday == 3'd0) ? WEEKDAY_MAX : d.weekday - 3'd1;
                     end
                  end
                  FIELD_DAY: begin
                     if (up) begin
                        next_state.date.day = (d.day >= cur_len) ? DAY_FIRST : d.day + 5'd1;
                     end else begin
                        next_state.date.day = (d.day <= DAY_FIRST) ? cur_len : d.day - 5'd1;
                     end
                  end
                  FIELD_MONTH: begin
                     next_state.date.month = new_month;
                     next_state.date.day   = (d.day > new_len) ? new_len : d.day;
                  end
                  default: begin
                     next_state.date.year = up ? d.year + 16'd1 : d.year - 16'd1;
                  end
               endcase
            end
         end
         CMD_REFRESH: begin
            if (!editing) begin
               next_state.date = clock_date;
            end
         end
         default: begin
            next_state = cur_state;
         end
      endcase
   end

endmodule

@@ sim/date_field_button_editor_test.sv @@
// Self-checking stream testbench for the date field button editor.
module date_field_button_editor_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dfbe_pkg::*;

   // Command codes the block treats as none
   localparam logic [2:0] CMD_SPARE_LOW  = 3'd6;
   localparam logic [2:0] CMD_SPARE_HIGH = 3'd7;
   localparam int         TIMEOUT_NS     = 5_000_000;

   // One result transaction as the block packs it on rsp_tdata
   typedef struct packed {
      logic      commit;
      field_type field;
      date_type  date;
   } editor_view_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;  // clock_weekday[2:0], clock_day[7:3],
                                  // clock_month[11:8], clock_year[27:12], zero[31:28]
   logic [2:0]  req_tuser  = '0;  // command[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // weekday[2:0], day[7:3], month[11:8], year[27:12],
                                  // selected_field[30:28], commit[31]

   // Shadow copy of the editor state
   date_type        shadow_date;
   field_type       shadow_field;
   editor_view_type expected_views[$];
   int              error_count  = 0;
   int              edit_count   = 0;
   bit              req_idle_on  = 1'b0;
   bit              rsp_idle_on  = 1'b0;
   int              rsp_stall_left = 0;

   date_field_button_editor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Days in a month; codes outside 1..12 count as long months
   function automatic logic [4:0] month_length(input logic [3:0] month,
                                               input logic [15:0] year);
      case (month)
         MONTH_FEB: return (year[1:0] == 2'd0) ? DAYS_FEB_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return DAYS_SHORT;
         default: return DAYS_LONG;
      endcase
   endfunction

   // Gap length: mostly none, often short, now and then long
   function automatic int pick_gap(input bit enabled);
      int roll;
      if (!enabled) return 0;
      roll = $urandom_range(99);
      if (roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic date_type make_date(input logic [2:0] weekday, input logic [4:0] day,
                                          input logic [3:0] month, input logic [15:0] year);
      date_type d;
      d.weekday = weekday;
      d.day     = day;
      d.month   = month;
      d.year    = year;
      return d;
   endfunction

   // Clock chip date: mostly a real date, sometimes raw bits
   function automatic date_type random_clock_date();
      date_type    d;
      logic [31:0] raw;
      int          roll;
      raw  = $urandom;
      roll = $urandom_range(99);
      if (roll < 20) return raw[27:0];
      d.weekday = 3'($urandom_range(0, 6));
      d.month   = 4'($urandom_range(1, 12));
      if (roll < 40)
         d.year = 16'hFFFF - 16'($urandom_range(0, 3));
      else if (roll < 60)
         d.year = 16'($urandom_range(0, 3));
      else
         d.year = raw[15:0];
      d.day = 5'($urandom_range(1, month_length(d.month, d.year)));
      return d;
   endfunction

   // Advance the shadow state by one command and queue the resulting view
   task automatic predict_edit(input logic [2:0] command, input date_type clock_date);
      editor_view_type view;
      logic            editing;
      logic            going_up;
      logic [4:0]      len;
      editing     = (shadow_field != FIELD_NONE);
      going_up    = (command == CMD_UP);
      len         = month_length(shadow_date.month, shadow_date.year);
      view.commit = 1'b0;
      case (command)
         CMD_ENTER: begin
            shadow_field = (shadow_field == FIELD_YEAR) ? FIELD_WEEKDAY
                                                        : field_type'(shadow_field + 3'd1);
         end
         CMD_BACK: begin
            if (editing) begin
               shadow_field = FIELD_NONE;
               view.commit  = 1'b1;
            end
         end
         CMD_UP, CMD_DOWN: begin
            if (editing) begin
               case (shadow_field)
                  FIELD_WEEKDAY: begin
                     if (going_up)
                        shadow_date.weekday = (shadow_date.weekday >= WEEKDAY_MAX)
                                              ? 3'd0 : shadow_date.weekday + 3'd1;
                     else
                        shadow_date.weekday = (shadow_date.weekday == 3'd0)
                                              ? WEEKDAY_MAX : shadow_date.weekday - 3'd1;
                  end
                  FIELD_DAY: begin
                     if (going_up)
                        shadow_date.day = (shadow_date.day >= len)
                                          ? DAY_FIRST : shadow_date.day + 5'd1;
                     else
                        shadow_date.day = (shadow_date.day <= DAY_FIRST)
                                          ? len : shadow_date.day - 5'd1;
                  end
                  FIELD_MONTH: begin
                     if (going_up)
                        shadow_date.month = (shadow_date.month >= MONTH_LAST)
                                            ? MONTH_FIRST : shadow_date.month + 4'd1;
                     else
                        shadow_date.month = (shadow_date.month <= MONTH_FIRST)
                                            ? MONTH_LAST : shadow_date.month - 4'd1;
                     // clamp the day to the new month
                     len = month_length(shadow_date.month, shadow_date.year);
                     if (shadow_date.day > len) shadow_date.day = len;
                  end
                  default: begin
                     shadow_date.year = going_up ? shadow_date.year + 16'd1
                                                 : shadow_date.year - 16'd1;
                  end
               endcase
            end
         end
         CMD_REFRESH: begin
            if (!editing) shadow_date = clock_date;
         end
         default: ;
      endcase
      view.field = shadow_field;
      view.date  = shadow_date;
      expected_views.push_back(view);
   endtask

   // Drive one request transaction, hold it until accepted, then maybe idle
   task automatic send_command(input logic [2:0] command, input date_type clock_date);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= command;
      req_tdata  <= {4'd0, clock_date};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_edit(command, clock_date);
      if (command != CMD_NONE && command != CMD_SPARE_LOW && command != CMD_SPARE_HIGH)
         edit_count++;
      gap = pick_gap(req_idle_on);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Drop valid and wait until every queued result has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Result side backpressure
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall_left = pick_gap(rsp_idle_on);
      end
   end

   // Compare each result transaction with the oldest expected view
   always @(posedge clock) begin
      editor_view_type got;
      editor_view_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got = rsp_tdata;
         if (expected_views.size() == 0) begin
            $display("%0t: unexpected result transaction %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_views.pop_front();
            compare_field("weekday", 16'(want.date.weekday), 16'(got.date.weekday));
            compare_field("day", 16'(want.date.day), 16'(got.date.day));
            compare_field("month", 16'(want.date.month), 16'(got.date.month));
            compare_field("year", want.date.year, got.date.year);
            compare_field("selected_field", 16'(want.field), 16'(got.field));
            compare_field("commit", 16'(want.commit), 16'(got.commit));
         end
      end
   end

   // Reset values, then the codes that do nothing
   task automatic test_reset_state();
      send_command(CMD_NONE, make_date(3'd7, 5'd31, 4'd15, 16'hFFFF));
      send_command(CMD_SPARE_LOW, make_date(3'd7, 5'd31, 4'd15, 16'hFFFF));
      send_command(CMD_SPARE_HIGH, make_date(3'd0, 5'd0, 4'd0, 16'd0));
   endtask

   // Back, up and down outside edit mode are ignored
   task automatic test_idle_commands();
      send_command(CMD_BACK, random_clock_date());
      send_command(CMD_UP, random_clock_date());
      send_command(CMD_DOWN, random_clock_date());
   endtask

   // Refresh with all-zero and all-one clock chip fields
   task automatic test_refresh_extremes();
      send_command(CMD_REFRESH, make_date(3'd0, 5'd0, 4'd0, 16'd0));
      send_command(CMD_REFRESH, make_date(3'd7, 5'd31, 4'd15, 16'hFFFF));
   endtask

   // Walk every field with wraps from out-of-range values, then commit
   task automatic test_field_edits();
      send_command(CMD_ENTER, random_clock_date());
      send_command(CMD_UP, random_clock_date());     // weekday above six wraps to zero
      send_command(CMD_DOWN, random_clock_date());   // zero wraps to six
      send_command(CMD_ENTER, random_clock_date());
      send_command(CMD_UP, random_clock_date());     // last day wraps to first
      send_command(CMD_DOWN, random_clock_date());   // first day wraps to last
      send_command(CMD_ENTER, random_clock_date());
      send_command(CMD_UP, random_clock_date());     // month above twelve wraps to one
      send_command(CMD_UP, random_clock_date());     // February clamps the day
      send_command(CMD_ENTER, random_clock_date());
      send_command(CMD_UP, random_clock_date());     // year wraps to zero
      send_command(CMD_DOWN, random_clock_date());
      send_command(CMD_REFRESH, make_date(3'd2, 5'd9, 4'd5, 16'd1999));  // dropped
      send_command(CMD_ENTER, random_clock_date());  // selection wraps to weekday
      send_command(CMD_BACK, random_clock_date());
      send_command(CMD_BACK, random_clock_date());
   endtask

   // Day zero and month zero going down, leap February clamp going up
   task automatic test_range_edges();
      send_command(CMD_REFRESH, make_date(3'd6, 5'd0, 4'd0, 16'd2020));
      send_command(CMD_ENTER, random_clock_date());
      send_command(CMD_ENTER, random_clock_date());
      send_command(CMD_DOWN, random_clock_date());
      send_command(CMD_ENTER, random_clock_date());
      send_command(CMD_DOWN, random_clock_date());
      send_command(CMD_UP, random_clock_date());
      send_command(CMD_UP, random_clock_date());
      send_command(CMD_BACK, random_clock_date());
   endtask

   // Mostly edit sessions with random content, the rest raw noise
   task automatic test_random_traffic(input int goal, input bit req_idle, input bit rsp_idle);
      int start;
      int roll;
      req_idle_on = req_idle;
      rsp_idle_on = rsp_idle;
      start       = edit_count;
      while (edit_count - start < goal) begin
         if ($urandom_range(99) < 80) begin
            if (shadow_field == FIELD_NONE && $urandom_range(1))
               send_command(CMD_REFRESH, random_clock_date());
            repeat ($urandom_range(1, 4)) send_command(CMD_ENTER, random_clock_date());
            repeat ($urandom_range(1, 10)) begin
               roll = $urandom_range(99);
               if (roll < 45)
                  send_command(CMD_UP, random_clock_date());
               else if (roll < 90)
                  send_command(CMD_DOWN, random_clock_date());
               else
                  send_command(CMD_ENTER, random_clock_date());
            end
            send_command(CMD_BACK, random_clock_date());
         end else begin
            send_command(3'($urandom_range(7)), random_clock_date());
         end
      end
   endtask

   // Hold off the sender until the result side is empty, then resume
   task automatic test_drain_pause();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      wait_for_results();
      test_random_traffic(50, 1'b1, 1'b1);
   endtask

   initial begin
      shadow_date  = make_date(RESET_WEEKDAY, RESET_DAY, RESET_MONTH, RESET_YEAR);
      shadow_field = FIELD_NONE;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_idle_commands();
      test_refresh_extremes();
      test_field_edits();
      test_range_edges();
      test_random_traffic(250, 1'b0, 1'b0);
      test_random_traffic(250, 1'b1, 1'b1);
      test_drain_pause();
      test_random_traffic(175, 1'b1, 1'b0);
      test_random_traffic(175, 1'b0, 1'b1);

      // Let stray results show up before the verdict
      wait_for_results();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
